// ===== rtl/swqt_pkg.sv =====
`timescale 1ns / 1ps
package swqt_pkg;

   localparam int KEY_W = 32;
   localparam int PID_W = 5;
   // widest process index any build may use (PROCS up to 256)
   localparam int IDX_MAX_W = 8;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE_HEAD = 2'd1,
      ACT_OUT = 2'd2,
      ACT_PEEK = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK = 2'd0,
      STS_NO_FREE = 2'd1,
      STS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_UNLINK,
      ST_LINK,
      ST_DONE
   } state_type;

   // command broadcast to every descriptor cell; only selected cells act
   typedef struct packed {
      logic clr;
      logic set_head;
      logic set_tail;
      logic alloc;
      logic [IDX_MAX_W-1:0] val;
      logic [KEY_W-1:0] key;
   } cell_cmd_type;

endpackage

// ===== rtl/semaphore_wait_queue_table_top.sv =====
`timescale 1ns / 1ps
// Sequencing: each request passes through the find, unlink and (for an in-range insert)
//   link steps of the sequencer over the cells, then the done state and the response register.
// A new request is taken only once the previous one has reached the response
//   register; requests are not overlapped.
// Reset: synchronous, active high; clears all descriptor and process flags at once.
module semaphore_wait_queue_table_top import swqt_pkg::*; #(
   parameter int PROCS = 32
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [39:0] req_tdata,   // [31:0] sem_key, [36:32] pid, rest zero
   input logic [1:0] req_tuser,    // [1:0] action
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [7:0] rsp_tdata,   // [4:0] pid_out, rest zero
   output logic [1:0] rsp_tuser    // [1:0] status
);

   localparam int PW = (PROCS > 1) ? $clog2(PROCS) : 1;

   state_type state_ff, state_in;

   // latched request
   action_type act_ff;
   logic [KEY_W-1:0] key_ff;
   logic [PID_W-1:0] pid_ff;
   logic range_ff;
   logic [PW-1:0] pix_ff;

   // find results
   logic [PROCS-1:0] khit_ff;
   logic [PROCS-1:0] phit_ff;
   logic [PW-1:0] khead_ff;
   logic pblk_ff;

   // process stores
   logic [PW-1:0] next_ff [PROCS];
   logic [PW-1:0] prev_ff [PROCS];
   logic [KEY_W-1:0] pkey_ff [PROCS];
   logic [PROCS-1:0] blk_ff;

   // result staging and response register
   status_type sts_ff, sts_in;
   logic [PID_W-1:0] pout_ff, pout_in;
   logic rsp_valid_ff;
   status_type rsp_sts_ff;
   logic [PID_W-1:0] rsp_pid_ff;

   // cell row
   cell_cmd_type cmd;
   logic [PROCS-1:0] sel;
   logic [PROCS:0] free_chain;
   logic [PROCS-1:0] first_free, active_v, khit_v, phit_v;
   logic [PW-1:0] head_v [PROCS];
   logic [PW-1:0] tail_v [PROCS];
   logic [KEY_W-1:0] pkey_rd;

   assign free_chain[0] = 1'b0;
   assign pkey_rd = pkey_ff[pix_ff];

   for (genvar i = 0; i < PROCS; i++) begin : g_cell
      swqt_cell #(.PW(PW)) u_cell (
         .clock(clock),
         .reset(reset),
         .cmd(cmd),
         .sel(sel[i]),
         .cmp_key(key_ff),
         .cmp_pkey(pkey_rd),
         .free_in(free_chain[i]),
         .free_out(free_chain[i+1]),
         .first_free(first_free[i]),
         .active(active_v[i]),
         .key_hit(khit_v[i]),
         .pkey_hit(phit_v[i]),
         .head(head_v[i]),
         .tail(tail_v[i])
      );
   end

   // one-hot selections over the cell row
   logic [PROCS-1:0] tgt_d, khit_live;
   logic [PW-1:0] khead_c, dhead, dtail, ltail;
   logic [PW-1:0] tgt_p, pn, pp;
   logic is_head, is_tail, do_unlink, orphan, any_free;

   always_comb begin
      khead_c = '0;
      dhead = '0;
      dtail = '0;
      ltail = '0;
      tgt_d = (act_ff == ACT_REMOVE_HEAD) ? khit_ff : phit_ff;
      khit_live = khit_ff & active_v;
      for (int i = 0; i < PROCS; i++) begin
         if (khit_v[i]) khead_c |= head_v[i];
         if (tgt_d[i]) begin
            dhead |= head_v[i];
            dtail |= tail_v[i];
         end
         if (khit_live[i]) ltail |= tail_v[i];
      end
   end

   assign tgt_p = (act_ff == ACT_REMOVE_HEAD) ? khead_ff : pix_ff;
   assign pn = next_ff[tgt_p];
   assign pp = prev_ff[tgt_p];
   assign is_head = (dhead == tgt_p);
   assign is_tail = (dtail == tgt_p);
   assign any_free = free_chain[PROCS];
   assign orphan = pblk_ff && !(|phit_ff)
                   && (act_ff == ACT_INSERT || act_ff == ACT_OUT);
   always_comb begin
      case (act_ff)
         ACT_REMOVE_HEAD: do_unlink = |khit_ff;
         ACT_INSERT, ACT_OUT: do_unlink = pblk_ff && (|phit_ff);
         default: do_unlink = 1'b0;
      endcase
   end

   // sequencer: next state, cell commands, results
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.key = key_ff;
      sel = '0;
      sts_in = sts_ff;
      pout_in = pout_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_FIND;
         end
         ST_FIND: state_in = ST_UNLINK;
         ST_UNLINK: begin
            if (do_unlink) begin
               sel = tgt_d;
               if (is_head && is_tail) begin
                  cmd.clr = 1'b1;
               end else if (is_head) begin
                  cmd.set_head = 1'b1;
                  cmd.val = IDX_MAX_W'(pn);
               end else if (is_tail) begin
                  cmd.set_tail = 1'b1;
                  cmd.val = IDX_MAX_W'(pp);
               end
            end
            sts_in = STS_NOT_FOUND;
            pout_in = '0;
            state_in = ST_DONE;
            case (act_ff)
               ACT_INSERT: begin
                  pout_in = pid_ff;
                  if (range_ff) state_in = ST_LINK;
               end
               ACT_REMOVE_HEAD, ACT_PEEK: begin
                  if (|khit_ff) begin
                     sts_in = STS_OK;
                     pout_in = PID_W'(khead_ff);
                  end
               end
               ACT_OUT: begin
                  if (do_unlink) begin
                     sts_in = STS_OK;
                     pout_in = pid_ff;
                  end
               end
               default: ;
            endcase
         end
         ST_LINK: begin
            state_in = ST_DONE;
            cmd.val = IDX_MAX_W'(pix_ff);
            if (|khit_live) begin
               sel = khit_live;
               cmd.set_tail = 1'b1;
               sts_in = STS_OK;
            end else if (any_free) begin
               sel = first_free;
               cmd.alloc = 1'b1;
               sts_in = STS_OK;
            end else begin
               sts_in = STS_NO_FREE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // hold the request and the find results
   always_ff @(posedge clock) begin
      sts_ff <= sts_in;
      pout_ff <= pout_in;
      if (state_ff == ST_IDLE && req_tvalid) begin
         act_ff <= action_type'(req_tuser);
         key_ff <= req_tdata[31:0];
         pid_ff <= req_tdata[36:32];
         range_ff <= (9'(req_tdata[36:32]) < 9'(PROCS));
         pix_ff <= PW'(req_tdata[36:32]);
      end
      if (state_ff == ST_FIND) begin
         khit_ff <= khit_v;
         phit_ff <= phit_v;
         khead_ff <= khead_c;
         pblk_ff <= blk_ff[pix_ff] && range_ff;
      end
   end

   // process stores: relink neighbors on unlink, append on link
   always_ff @(posedge clock) begin
      if (state_ff == ST_UNLINK && do_unlink && !is_head && !is_tail) begin
         next_ff[pp] <= pn;
         prev_ff[pn] <= pp;
      end
      if (state_ff == ST_LINK) begin
         if (|khit_live) begin
            next_ff[ltail] <= pix_ff;
            prev_ff[pix_ff] <= ltail;
         end
         if ((|khit_live) || any_free) pkey_ff[pix_ff] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff <= '0;
      end else if (state_ff == ST_UNLINK) begin
         if (do_unlink) blk_ff[tgt_p] <= 1'b0;
         else if (orphan) blk_ff[pix_ff] <= 1'b0;
      end else if (state_ff == ST_LINK && ((|khit_live) || any_free)) begin
         blk_ff[pix_ff] <= 1'b1;
      end
   end

   // response register: advance when the consumer takes the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_sts_ff <= sts_ff;
         rsp_pid_ff <= pout_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, rsp_pid_ff};
   assign rsp_tuser = rsp_sts_ff;

endmodule

// ===== rtl/swqt_cell.sv =====
`timescale 1ns / 1ps
module swqt_cell import swqt_pkg::*; #(
   parameter int PW = 5
) (
   input logic clock,
   input logic reset,
   input cell_cmd_type cmd,
   input logic sel,
   input logic [KEY_W-1:0] cmp_key,
   input logic [KEY_W-1:0] cmp_pkey,
   input logic free_in,
   output logic free_out,
   output logic first_free,
   output logic active,
   output logic key_hit,
   output logic pkey_hit,
   output logic [PW-1:0] head,
   output logic [PW-1:0] tail
);

   logic active_ff;
   logic [KEY_W-1:0] key_ff;
   logic [PW-1:0] head_ff;
   logic [PW-1:0] tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (sel) begin
         if (cmd.clr) active_ff <= 1'b0;
         else if (cmd.alloc) active_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         if (cmd.alloc) begin
            key_ff <= cmd.key;
            head_ff <= cmd.val[PW-1:0];
            tail_ff <= cmd.val[PW-1:0];
         end else begin
            if (cmd.set_head) head_ff <= cmd.val[PW-1:0];
            if (cmd.set_tail) tail_ff <= cmd.val[PW-1:0];
         end
      end
   end

   // free chain: lowest inactive cell claims the allocation
   assign first_free = !active_ff && !free_in;
   assign free_out = free_in || !active_ff;
   assign active = active_ff;
   assign key_hit = active_ff && (key_ff == cmp_key);
   assign pkey_hit = active_ff && (key_ff == cmp_pkey);
   assign head = head_ff;
   assign tail = tail_ff;

endmodule

// ===== tb/sv/semaphore_wait_queue_table_checker.sv =====
`timescale 1ns / 1ps
module semaphore_wait_queue_table_checker import swqt_pkg::*; #(
   parameter int PROCS = 32
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [39:0] req_tdata,
   input logic [1:0] req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   output int fail_count,
   output int pending_count
);

   typedef struct packed {
      status_type status;
      logic [PID_W-1:0] pid_out;
   } sem_reply_type;

   logic [KEY_W-1:0] sem_key_of [PROCS];
   logic sem_live [PROCS];
   logic [PID_W-1:0] q_first [PROCS];
   logic [PID_W-1:0] q_last [PROCS];
   logic [PID_W-1:0] p_succ [PROCS];
   logic [PID_W-1:0] p_pred [PROCS];
   logic [KEY_W-1:0] p_waits_on [PROCS];
   logic p_waiting [PROCS];

   sem_reply_type reply_queue[$];

   function automatic int lookup_sem(logic [KEY_W-1:0] k);
      for (int d = 0; d < PROCS; d++)
         if (sem_live[d] && sem_key_of[d] == k) return d;
      return -1;
   endfunction

   function automatic void detach(int d, logic [PID_W-1:0] p);
      logic h;
      logic t;
      h = (q_first[d] == p);
      t = (q_last[d] == p);
      if (h && t) sem_live[d] = 1'b0;
      else if (h) q_first[d] = p_succ[p];
      else if (t) q_last[d] = p_pred[p];
      else begin
         p_succ[p_pred[p]] = p_succ[p];
         p_pred[p_succ[p]] = p_pred[p];
      end
      p_waiting[p] = 1'b0;
   endfunction

   function automatic logic pull_proc(logic [PID_W-1:0] p);
      int d;
      if (!p_waiting[p]) return 1'b0;
      d = lookup_sem(p_waits_on[p]);
      if (d < 0) begin
         p_waiting[p] = 1'b0;
         return 1'b0;
      end
      detach(d, p);
      return 1'b1;
   endfunction

   function automatic sem_reply_type predict_wait_table(action_type act,
         logic [KEY_W-1:0] k, logic [PID_W-1:0] p);
      sem_reply_type r;
      int d;
      int f;
      r.status = STS_NOT_FOUND;
      r.pid_out = '0;
      case (act)
         ACT_INSERT: begin
            r.pid_out = p;
            if (int'(p) < PROCS) begin
               d = lookup_sem(k);
               if (p_waiting[p]) void'(pull_proc(p));
               if (d >= 0) d = lookup_sem(k);
               if (d < 0) begin
                  f = 0;
                  while (f < PROCS && sem_live[f]) f++;
                  if (f >= PROCS) r.status = STS_NO_FREE;
                  else begin
                     sem_live[f] = 1'b1;
                     sem_key_of[f] = k;
                     q_first[f] = p;
                     q_last[f] = p;
                     p_waits_on[p] = k;
                     p_waiting[p] = 1'b1;
                     r.status = STS_OK;
                  end
               end else begin
                  p_succ[q_last[d]] = p;
                  p_pred[p] = q_last[d];
                  q_last[d] = p;
                  p_waits_on[p] = k;
                  p_waiting[p] = 1'b1;
                  r.status = STS_OK;
               end
            end
         end
         ACT_REMOVE_HEAD: begin
            d = lookup_sem(k);
            if (d >= 0) begin
               r.pid_out = q_first[d];
               detach(d, q_first[d]);
               r.status = STS_OK;
            end
         end
         ACT_OUT: begin
            if (int'(p) < PROCS && pull_proc(p)) begin
               r.status = STS_OK;
               r.pid_out = p;
            end
         end
         default: begin
            d = lookup_sem(k);
            if (d >= 0) begin
               r.status = STS_OK;
               r.pid_out = q_first[d];
            end
         end
      endcase
      return r;
   endfunction

   assign pending_count = reply_queue.size();

   always @(posedge clock) begin
      sem_reply_type want;
      if (reset) begin
         for (int i = 0; i < PROCS; i++) begin
            sem_live[i] <= 1'b0;
            p_waiting[i] <= 1'b0;
         end
         reply_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            reply_queue.push_back(predict_wait_table(action_type'(req_tuser),
               req_tdata[31:0], req_tdata[36:32]));
         if (rsp_tvalid && rsp_tready) begin
            if (reply_queue.size() == 0) begin
               $display("%0t: unexpected transfer status=%0d pid_out=%0d", $time,
                  rsp_tuser, rsp_tdata[4:0]);
               fail_count <= fail_count + 1;
            end else begin
               want = reply_queue.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata[4:0] !== want.pid_out
                     || rsp_tdata[7:5] !== 3'b0) begin
                  $display({"%0t: mismatch expected status=%0d pid_out=%0d",
                     " actual status=%0d tdata=%0h"},
                     $time, want.status, want.pid_out, rsp_tuser, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/sv/tb_semaphore_wait_queue_table_top.sv =====
`timescale 1ns / 1ps
module tb_semaphore_wait_queue_table_top;
   import swqt_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;   // [31:0] sem_key, [36:32] pid, rest zero
   logic [1:0] req_tuser = '0;    // [1:0] action
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [4:0] pid_out, rest zero
   logic [1:0] rsp_tuser;         // [1:0] status
   int fail_count;
   int pending_count;

   // idle percentages for each side, switched per phase
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;              // cycles of forced receiver stall left
   logic [31:0] key_pool [8];

   always #10 clock = ~clock;

   semaphore_wait_queue_table_top i_dut (.*);

   semaphore_wait_queue_table_checker i_chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .pending_count
   );

   // receiver: random stalls, plus a long hold-off counted here
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // offer one item, hold it until the transfer, with random idle first
   task automatic send_item(action_type act, logic [31:0] k, logic [4:0] p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {3'b0, p, k};
      do @(posedge clock); while (!req_tready);
   endtask

   // draw keys mostly from a small pool so queues grow and collide
   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 85) return key_pool[$urandom_range(7)];
      if (r < 90) return 32'h0;
      if (r < 95) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic random_items(int n, int pool_keys);
      action_type act;
      for (int i = 0; i < n; i++) begin
         act = action_type'($urandom_range(3));
         if ($urandom_range(99) < 40) act = ACT_INSERT;
         if (pool_keys > 0) send_item(act, pick_key(), 5'($urandom_range(31)));
         else send_item(act, $urandom, 5'($urandom_range(31)));
      end
   endtask

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, every action
      send_item(ACT_PEEK, 32'h0, 5'd0);
      send_item(ACT_REMOVE_HEAD, 32'hFFFF_FFFF, 5'd0);
      send_item(ACT_OUT, 32'h0, 5'd31);
      send_item(ACT_INSERT, 32'hFFFF_FFFF, 5'd31);
      send_item(ACT_INSERT, 32'hFFFF_FFFF, 5'd0);
      send_item(ACT_INSERT, 32'h0, 5'd7);
      send_item(ACT_PEEK, 32'hFFFF_FFFF, 5'd0);
      // move a blocked process to another key
      send_item(ACT_INSERT, 32'h0, 5'd31);
      send_item(ACT_INSERT, 32'h5555_AAAA, 5'd7);
      send_item(ACT_OUT, 32'h0, 5'd31);
      send_item(ACT_OUT, 32'h0, 5'd31);
      send_item(ACT_REMOVE_HEAD, 32'hFFFF_FFFF, 5'd0);
      send_item(ACT_REMOVE_HEAD, 32'hFFFF_FFFF, 5'd0);
      send_item(ACT_PEEK, 32'h5555_AAAA, 5'd0);
      // fill every descriptor, then ask for one more
      for (int p = 0; p < 32; p++) send_item(ACT_INSERT, 32'h100 + p, p[4:0]);
      send_item(ACT_INSERT, 32'hAAAA_5555, 5'd3);
      for (int p = 0; p < 32; p++) send_item(ACT_REMOVE_HEAD, 32'h100 + p, 5'd0);

      // no idling
      random_items(300, 1);
      // sender idle
      send_idle_pct = 47;
      random_items(300, 1);
      // receiver stalling, with one long hold-off while the sender keeps offering
      send_idle_pct = 0;
      recv_stall_pct = 47;
      hold_off = 300;
      random_items(400, 1);
      // both
      send_idle_pct = 12;
      recv_stall_pct = 12;
      random_items(700, 1);
      random_items(50, 0);
      req_tvalid <= 1'b0;
      recv_stall_pct = 0;

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/swqt_pkg.sv
rtl/swqt_cell.sv
rtl/semaphore_wait_queue_table_top.sv
tb/sv/semaphore_wait_queue_table_checker.sv
tb/sv/tb_semaphore_wait_queue_table_top.sv
